// ===== design/rankf_pkg.sv =====
package rankf_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int PIXEL_BITS_DEF = 16;

	localparam int MODE_W     = 2;
	localparam int FWIDTH_W   = 12;
	localparam int FHEIGHT_W  = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

	localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MIN    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MAX    = 2'd2;

	localparam logic [FWIDTH_W-1:0]  FRAME_WIDTH_RST  = 12'd640;
	localparam logic [FHEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd480;

	localparam int FIFO_DEPTH = 8;
	localparam int WIN_CELLS  = 9;

	// per-request control that travels with the window
	typedef struct packed {
		logic emit1;   // centre at window column 1
		logic left1;
		logic emit2;   // extra centre at window column 2 (last column)
		logic left2;
		logic top_ok;
		logic bot_ok;
		logic done2;
	} ctl_t;

endpackage

// ===== design/rankf_in_if.sv =====
interface rankf_in_if #(
	parameter int PIXEL_BITS = rankf_pkg::PIXEL_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] in_pixel;

	modport source (output valid, output in_pixel, input ready);
	modport sink (input valid, input in_pixel, output ready);
endinterface

// ===== design/rankf_out_if.sv =====
interface rankf_out_if #(
	parameter int PIXEL_BITS = rankf_pkg::PIXEL_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] out_pixel;
	logic                  frame_done;
	logic                  run_last;

	modport source (output valid, output out_pixel, output frame_done, output run_last,
		input ready);
	modport sink (input valid, input out_pixel, input frame_done, input run_last,
		output ready);
endinterface

// ===== design/rank_filter_3x3_truncated_border.sv =====
// channel   | dir | payload                          | handshake
// pixels    | in  | in_pixel                         | valid/ready
// results   | out | out_pixel, frame_done, run_last  | valid/ready
// cfg       | in  | cfg_index, cfg_data              | cfg_we, no wait
//
// One pixel request per cycle while pixels.ready is high. A result passes the line store
// read, then the window shift and rank select, and waits in the output queue until taken.
// Last column requests produce up to two results; the 8-entry output queue absorbs them
// and pixels.ready drops when the queue could not hold the results in flight plus two.
// Reset clears control and window; line stores are not cleared.
module rank_filter_3x3_truncated_border #(
	parameter int MAX_WIDTH  = rankf_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = rankf_pkg::PIXEL_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rankf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rankf_pkg::CFG_DATA_W-1:0]   cfg_data,
	rankf_in_if.sink                           pixels,
	rankf_out_if.source                        results
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = rankf_pkg::FHEIGHT_W;
	localparam int RW = PIXEL_BITS + 2;
	localparam int CW = $clog2(rankf_pkg::FIFO_DEPTH + 1);

	logic [rankf_pkg::MODE_W-1:0] mode_q;
	logic [rankf_pkg::FWIDTH_W-1:0] fwidth_q;
	logic [HW-1:0] fheight_q;
	logic [XW-1:0] col_q;
	logic [HW-1:0] row_q;
	logic          primed_q;

	logic [WW-1:0] w_eff, x_ext;
	logic [HW-1:0] h_eff, cr;
	logic          acc;
	rankf_pkg::ctl_t ctl, ctl_s1, ctl_s2;
	logic          v_s1, v_s2;
	logic [PIXEL_BITS-1:0] win [rankf_pkg::WIN_CELLS];
	logic [rankf_pkg::WIN_CELLS-1:0] mask1, mask2;
	logic [PIXEL_BITS-1:0] res1, res2;
	logic [1:0]    push_n;
	logic [RW-1:0] d0, d1, fq;
	logic [CW-1:0] fcnt;
	logic [CW:0]   need;
	logic          fvalid;

	always_comb begin
		if (fwidth_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(fwidth_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(fwidth_q);
		end
	end

	assign h_eff = (fheight_q == '0) ? HW'(1) : fheight_q;
	assign x_ext = WW'(col_q);
	assign cr    = (row_q == '0) ? h_eff - HW'(1) : row_q - HW'(1);

	always_comb begin
		ctl.emit1  = primed_q && (col_q != '0);
		ctl.left1  = col_q > XW'(1);
		ctl.emit2  = primed_q && (x_ext == w_eff - WW'(1));
		ctl.left2  = w_eff > WW'(1);
		ctl.top_ok = cr != '0;
		ctl.bot_ok = cr != h_eff - HW'(1);
		ctl.done2  = cr == h_eff - HW'(1);
	end

	// room for the worst case of everything in flight plus this request
	assign need = {1'b0, fcnt}
		+ (v_s1 ? (CW+1)'(ctl_s1.emit1) + (CW+1)'(ctl_s1.emit2) : '0)
		+ (v_s2 ? (CW+1)'(ctl_s2.emit1) + (CW+1)'(ctl_s2.emit2) : '0)
		+ (CW+1)'(2);
	assign pixels.ready = need <= (CW+1)'(rankf_pkg::FIFO_DEPTH);
	assign acc = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= rankf_pkg::MODE_MEDIAN;
			fwidth_q  <= rankf_pkg::FRAME_WIDTH_RST;
			fheight_q <= rankf_pkg::FRAME_HEIGHT_RST;
			col_q     <= '0;
			row_q     <= '0;
			primed_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				rankf_pkg::REG_FILTER_MODE: begin
					mode_q <= cfg_data[rankf_pkg::MODE_W-1:0];
				end
				rankf_pkg::REG_FRAME_WIDTH: begin
					fwidth_q <= cfg_data[rankf_pkg::FWIDTH_W-1:0];
					col_q    <= '0;
					row_q    <= '0;
					primed_q <= 1'b0;
				end
				rankf_pkg::REG_FRAME_HEIGHT: begin
					fheight_q <= cfg_data[HW-1:0];
					col_q     <= '0;
					row_q     <= '0;
					primed_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end else if (acc) begin
			if (x_ext + WW'(1) >= w_eff) begin
				col_q    <= '0;
				primed_q <= 1'b1;
				row_q    <= ({1'b0, row_q} + 17'd1 >= {1'b0, h_eff}) ? '0 : row_q + HW'(1);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	rankf_window #(
		.MAX_WIDTH(MAX_WIDTH),
		.PIXEL_BITS(PIXEL_BITS)
	) u_window (
		.clk(clk),
		.arst_n(arst_n),
		.acc(acc),
		.pixel(pixels.in_pixel),
		.col(col_q),
		.ctl(ctl),
		.v_s1(v_s1),
		.ctl_s1(ctl_s1),
		.v_s2(v_s2),
		.ctl_s2(ctl_s2),
		.win(win)
	);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			logic rv;
			rv = (r == 0) ? ctl_s2.top_ok : ((r == 2) ? ctl_s2.bot_ok : 1'b1);
			mask1[r*3]   = rv && ctl_s2.left1;
			mask1[r*3+1] = rv;
			mask1[r*3+2] = rv;
			mask2[r*3]   = 1'b0;
			mask2[r*3+1] = rv && ctl_s2.left2;
			mask2[r*3+2] = rv;
		end
	end

	rankf_rank #(.PIXEL_BITS(PIXEL_BITS)) u_rank1 (
		.cells(win),
		.mask(mask1),
		.mode(mode_q),
		.result(res1)
	);

	rankf_rank #(.PIXEL_BITS(PIXEL_BITS)) u_rank2 (
		.cells(win),
		.mask(mask2),
		.mode(mode_q),
		.result(res2)
	);

	assign push_n = v_s2 ? {1'b0, ctl_s2.emit1} + {1'b0, ctl_s2.emit2} : 2'd0;
	assign d1 = {res2, ctl_s2.done2, 1'b1};
	assign d0 = ctl_s2.emit1 ? {res1, 1'b0, !ctl_s2.emit2} : d1;

	rankf_fifo #(
		.W(RW),
		.DEPTH(rankf_pkg::FIFO_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_n(push_n),
		.d0(d0),
		.d1(d1),
		.pop(results.ready),
		.valid(fvalid),
		.q(fq),
		.count(fcnt)
	);

	assign results.valid      = fvalid;
	assign results.out_pixel  = fq[RW-1:2];
	assign results.frame_done = fq[1];
	assign results.run_last   = fq[0];

endmodule

// ===== design/rankf_window.sv =====
module rankf_window #(
	parameter int MAX_WIDTH  = rankf_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = rankf_pkg::PIXEL_BITS_DEF,
	localparam int XW = $clog2(MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  acc,
	input  logic [PIXEL_BITS-1:0] pixel,
	input  logic [XW-1:0]         col,
	input  rankf_pkg::ctl_t       ctl,
	output logic                  v_s1,
	output rankf_pkg::ctl_t       ctl_s1,
	output logic                  v_s2,
	output rankf_pkg::ctl_t       ctl_s2,
	output logic [PIXEL_BITS-1:0] win [rankf_pkg::WIN_CELLS]
);

	logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
	logic [PIXEL_BITS-1:0] middle_mem [MAX_WIDTH];

	logic [PIXEL_BITS-1:0] rd_a_s1, rd_b_s1, p_s1;
	logic [PIXEL_BITS-1:0] byp_a_s1, byp_b_s1;
	logic                  byp_s1;
	logic [XW-1:0]         x_s1;
	logic [PIXEL_BITS-1:0] a_eff, b_eff;
	logic [PIXEL_BITS-1:0] win_q [rankf_pkg::WIN_CELLS];

	// previous request writes the column in the same cycle this one reads it
	assign a_eff = byp_s1 ? byp_a_s1 : rd_a_s1;
	assign b_eff = byp_s1 ? byp_b_s1 : rd_b_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_a_s1 <= upper_mem[col];
			rd_b_s1 <= middle_mem[col];
		end
		if (v_s1) begin
			upper_mem[x_s1]  <= b_eff;
			middle_mem[x_s1] <= p_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			p_s1     <= pixel;
			x_s1     <= col;
			byp_a_s1 <= b_eff;
			byp_b_s1 <= p_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			byp_s1 <= 1'b0;
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			for (int i = 0; i < rankf_pkg::WIN_CELLS; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			if (acc) begin
				ctl_s1 <= ctl;
				byp_s1 <= v_s1 && (col == x_s1);
			end
			if (v_s1) begin
				ctl_s2 <= ctl_s1;
				for (int r = 0; r < 3; r++) begin
					win_q[r*3]   <= win_q[r*3+1];
					win_q[r*3+1] <= win_q[r*3+2];
				end
				win_q[2] <= a_eff;
				win_q[5] <= b_eff;
				win_q[8] <= p_s1;
			end
		end
	end

	assign win = win_q;

endmodule

// ===== design/rankf_rank.sv =====
module rankf_rank #(
	parameter int PIXEL_BITS = rankf_pkg::PIXEL_BITS_DEF
) (
	input  logic [PIXEL_BITS-1:0]          cells [rankf_pkg::WIN_CELLS],
	input  logic [rankf_pkg::WIN_CELLS-1:0] mask,
	input  logic [rankf_pkg::MODE_W-1:0]   mode,
	output logic [PIXEL_BITS-1:0]          result
);

	// element of rank k: count smaller members, ties broken by position
	always_comb begin
		logic [3:0] n;
		logic [3:0] k;
		logic [3:0] rk;
		n      = '0;
		k      = '0;
		rk     = '0;
		result = '0;
		for (int i = 0; i < rankf_pkg::WIN_CELLS; i++) begin
			n = n + {3'd0, mask[i]};
		end
		case (mode)
			rankf_pkg::MODE_MIN: k = 4'd0;
			rankf_pkg::MODE_MAX: k = n - 4'd1;
			default:             k = (n - 4'd1) >> 1;
		endcase
		for (int i = 0; i < rankf_pkg::WIN_CELLS; i++) begin
			rk = '0;
			for (int j = 0; j < rankf_pkg::WIN_CELLS; j++) begin
				if (mask[j] && ((cells[j] < cells[i]) || ((cells[j] == cells[i]) && (j < i))))
				begin
					rk = rk + 4'd1;
				end
			end
			if (mask[i] && rk == k) begin
				result = result | cells[i];
			end
		end
	end

endmodule

// ===== design/rankf_fifo.sv =====
module rankf_fifo #(
	parameter int W     = rankf_pkg::PIXEL_BITS_DEF + 2,
	parameter int DEPTH = rankf_pkg::FIFO_DEPTH,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_n,
	input  logic [W-1:0]  d0,
	input  logic [W-1:0]  d1,
	input  logic          pop,
	output logic          valid,
	output logic [W-1:0]  q,
	output logic [CW-1:0] count
);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	assign valid  = cnt_q != '0;
	assign q      = mem_q[rp_q];
	assign count  = cnt_q;
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wp_q] <= d0;
		end
		if (push_n == 2'd2) begin
			mem_q[wp_q + PW'(1)] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(push_n);
			rp_q  <= rp_q + PW'(do_pop);
			cnt_q <= cnt_q + CW'(push_n) - CW'(do_pop);
		end
	end

endmodule
